FILE: design/tpakd_pkg.sv
// Shared types and constants of the touch pad activity key detector.
// No dependencies.
package tpakd_pkg;

   localparam int LevelBits = 12;
   localparam int BaseBits  = 24;
   localparam int RdBits    = 16;
   localparam int MixBits   = 16;
   localparam int WarmBits  = 8;
   localparam int CountBits = 3;
   localparam int NumBits   = 36;
   localparam int DenBits   = 26;
   localparam int IncBits   = 14;
   localparam int AccBits   = 27;
   localparam int CsrBits   = 16;

   typedef enum logic [2:0] {
      REG_LEVEL_CEILING  = 3'd0,
      REG_LEVEL_BLEED    = 3'd1,
      REG_WARMUP_SAMPLES = 3'd2,
      REG_BASELINE_MIX   = 3'd3,
      REG_TOUCH_LEVEL    = 3'd4,
      REG_PAIR_LEVEL     = 3'd5,
      REG_SINGLE_LEVEL   = 3'd6,
      REG_MIDDLE_COUNT   = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      KEY_NONE       = 3'd0,
      KEY_RIGHT      = 3'd1,
      KEY_UP         = 3'd2,
      KEY_LEFT       = 3'd3,
      KEY_DOWN       = 3'd4,
      KEY_MIDDLE     = 3'd5,
      KEY_DOWN_LEFT  = 3'd6,
      KEY_DOWN_RIGHT = 3'd7
   } key_type;

   typedef enum logic [2:0] {
      LN_IDLE, LN_DIV_WARM, LN_MUL, LN_MIX, LN_DEV, LN_DIV_DEV, LN_FIN
   } lane_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE, TOP_START, TOP_RUN, TOP_DONE
   } top_state_type;

   typedef struct packed {
      logic [LevelBits-1:0] ceiling;
      logic [LevelBits-1:0] bleed;
      logic [WarmBits-1:0]  warmup;
      logic [MixBits-1:0]   mix;
   } lane_cfg_type;

   typedef struct packed {
      logic [LevelBits-1:0] touch;
      logic [LevelBits-1:0] pair;
      logic [LevelBits-1:0] single;
      logic [CountBits-1:0] middle;
   } key_cfg_type;

endpackage

FILE: design/tpakd_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tpakd_pkg.
module tpakd_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tpakd_pkg::NumBits-1:0]   num,
   input  logic [tpakd_pkg::DenBits-1:0]   den,
   output logic                            busy,
   output logic [tpakd_pkg::NumBits-1:0]   quo
);
   import tpakd_pkg::*;

   localparam int CntBits = $clog2(NumBits + 1);

   logic [NumBits-1:0] quo_ff, quo_in;
   logic [DenBits:0]   rem_ff, rem_in;
   logic [DenBits-1:0] den_ff, den_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic [DenBits:0]   rem_sh;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      rem_sh = {rem_ff[DenBits-1:0], quo_ff[NumBits-1]};
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CntBits'(NumBits);
      end else if (cnt_ff != '0) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[NumBits-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[NumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy = (cnt_ff != '0);
   assign quo  = quo_ff;

endmodule

FILE: design/tpakd_lane.sv
// One channel lane: activity level, baseline and previous reading of one pad.
// Depends on tpakd_pkg and tpakd_div.
module tpakd_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             warm,
   input  logic [tpakd_pkg::RdBits-1:0]     reading,
   input  tpakd_pkg::lane_cfg_type          cfg,
   output logic                             busy,
   output logic [tpakd_pkg::LevelBits-1:0]  level
);
   import tpakd_pkg::*;

   lane_state_type state_ff, state_in;

   logic [BaseBits-1:0]  base_ff, base_in;
   logic [LevelBits-1:0] level_ff, level_in;
   logic [RdBits-1:0]    prev_ff, prev_in;
   logic [RdBits-1:0]    rd_ff;
   logic                 warm_ff;
   logic signed [AccBits-1:0] acc_ff;
   logic [40:0]          p1_ff;
   logic [39:0]          p2_ff;
   logic [BaseBits-1:0]  nb_ff;

   logic [RdBits-1:0]    diff;
   logic [BaseBits-1:0]  r8, r8_ff;
   logic [41:0]          mix_sum;
   logic [BaseBits-1:0]  dev;
   logic                 div_start;
   logic [NumBits-1:0]   div_num;
   logic [DenBits-1:0]   div_den;
   logic                 div_busy;
   logic [NumBits-1:0]   quo;
   logic [BaseBits:0]    warm_sum;
   logic [IncBits-1:0]   inc;
   logic signed [AccBits-1:0] acc_sum;

   tpakd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (quo)
   );

   assign diff    = (reading > prev_ff) ? reading - prev_ff : prev_ff - reading;
   assign r8      = {reading, 8'h00};
   assign r8_ff   = {rd_ff, 8'h00};
   assign mix_sum = 42'(p1_ff) + 42'(p2_ff) + 42'd32768;
   assign dev     = (r8_ff > nb_ff) ? r8_ff - nb_ff : nb_ff - r8_ff;
   assign warm_sum = {1'b0, base_ff} + {1'b0, quo[BaseBits-1:0]};

   always_comb begin
      if (warm_ff) begin
         inc = '0;
      end else if (nb_ff == '0) begin
         inc = IncBits'(4096);
      end else if (quo[NumBits-1:13] != '0) begin
         inc = IncBits'(8191);
      end else begin
         inc = {1'b0, quo[12:0]};
      end
   end

   assign acc_sum = acc_ff + AccBits'(inc);

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = {12'h000, r8};
      div_den   = {18'h00000, cfg.warmup};
      base_in   = base_ff;
      level_in  = level_ff;
      prev_in   = prev_ff;
      case (state_ff)
         LN_IDLE: begin
            if (start) begin
               prev_in = reading;
               if (warm) begin
                  div_start = 1'b1;
                  state_in  = LN_DIV_WARM;
               end else begin
                  state_in = LN_MUL;
               end
            end
         end
         LN_DIV_WARM: begin
            if (!div_busy) state_in = LN_FIN;
         end
         LN_MUL: state_in = LN_MIX;
         LN_MIX: state_in = LN_DEV;
         LN_DEV: begin
            if (nb_ff == '0) begin
               state_in = LN_FIN;
            end else begin
               div_start = 1'b1;
               div_num   = (NumBits'(dev) << 11) + (NumBits'(dev) << 9);
               div_den   = (DenBits'(nb_ff) << 1) + DenBits'(nb_ff);
               state_in  = LN_DIV_DEV;
            end
         end
         LN_DIV_DEV: begin
            if (!div_busy) state_in = LN_FIN;
         end
         LN_FIN: begin
            if (warm_ff) begin
               base_in = warm_sum[BaseBits] ? {BaseBits{1'b1}} : warm_sum[BaseBits-1:0];
            end else begin
               base_in = nb_ff;
            end
            if (acc_sum < 0) begin
               level_in = '0;
            end else if (acc_sum > $signed(AccBits'(cfg.ceiling))) begin
               level_in = cfg.ceiling;
            end else begin
               level_in = acc_sum[LevelBits-1:0];
            end
            state_in = LN_IDLE;
         end
         default: state_in = LN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LN_IDLE;
         base_ff  <= '0;
         level_ff <= '0;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         level_ff <= level_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == LN_IDLE && start) begin
         rd_ff   <= reading;
         warm_ff <= warm;
         acc_ff  <= $signed(AccBits'(level_ff)) + $signed(AccBits'({diff, 8'h00}))
                    - $signed(AccBits'(cfg.bleed));
      end
      if (state_ff == LN_MUL) begin
         p1_ff <= base_ff * (17'h10000 - {1'b0, cfg.mix});
         p2_ff <= r8_ff * cfg.mix;
      end
      if (state_ff == LN_MIX) begin
         nb_ff <= mix_sum[39:16];
      end
   end

   assign busy  = (state_ff != LN_IDLE);
   assign level = level_ff;

endmodule

FILE: design/tpakd_merge.sv
// Merging stage: counts touched lanes and picks the key code by priority.
// Depends on tpakd_pkg.
module tpakd_merge (
   input  logic [tpakd_pkg::LevelBits-1:0] lv_right,
   input  logic [tpakd_pkg::LevelBits-1:0] lv_up,
   input  logic [tpakd_pkg::LevelBits-1:0] lv_left,
   input  logic [tpakd_pkg::LevelBits-1:0] lv_down,
   input  tpakd_pkg::key_cfg_type          cfg,
   output tpakd_pkg::key_type              key
);
   import tpakd_pkg::*;

   logic [CountBits-1:0] touched;

   assign touched = CountBits'(lv_right > cfg.touch) + CountBits'(lv_up > cfg.touch)
                  + CountBits'(lv_left > cfg.touch) + CountBits'(lv_down > cfg.touch);

   always_comb begin
      if (touched >= cfg.middle) begin
         key = KEY_MIDDLE;
      end else if (lv_left > cfg.pair && lv_down > cfg.pair) begin
         key = KEY_DOWN_LEFT;
      end else if (lv_right > cfg.pair && lv_down > cfg.pair) begin
         key = KEY_DOWN_RIGHT;
      end else if (lv_right > cfg.single) begin
         key = KEY_RIGHT;
      end else if (lv_up > cfg.single) begin
         key = KEY_UP;
      end else if (lv_left > cfg.single) begin
         key = KEY_LEFT;
      end else if (lv_down > cfg.single) begin
         key = KEY_DOWN;
      end else begin
         key = KEY_NONE;
      end
   end

endmodule

FILE: design/touch_pad_activity_key_detector.sv
// Top level: four lanes run side by side on one word, then the key is merged.
// Warm-up and tracking passes both wait on the 36-step lane divider; a tracking word
// whose new baseline is zero skips the divider. One word is taken per pass: no new word
// is accepted until the previous result has been loaded into the output register, and
// that load waits for rsp_tready while an older result is still held there.
// A word can be accepted while the previous result waits in the output register.
// Synchronous reset clears levels, baselines, previous readings, the warm-up counter
// and loads the register defaults.
// Depends on tpakd_pkg, tpakd_lane and tpakd_merge.
module touch_pad_activity_key_detector #(
   parameter int READING_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // reading_right, reading_up, reading_left, reading_down
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // key_code, level_right, level_up, level_left, level_down, zero fill
   output logic [55:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [tpakd_pkg::CsrBits-1:0] csr_wdata
);
   import tpakd_pkg::*;

   localparam int Lanes = 4;

   logic [LevelBits-1:0] ceiling_ff, bleed_ff, touch_ff, pair_ff, single_ff;
   logic [WarmBits-1:0]  warmup_ff;
   logic [MixBits-1:0]   mix_ff;
   logic [CountBits-1:0] middle_ff;
   logic [WarmBits-1:0]  wcnt_ff, wcnt_in;
   logic                 warm_ff, warm_in;

   top_state_type state_ff, state_in;
   logic                 out_valid_ff, out_valid_in;
   logic [55:0]          out_data_ff;
   logic                 load_out;

   logic [Lanes-1:0]     lane_busy;
   logic [LevelBits-1:0] lane_level [Lanes];
   logic [RdBits-1:0]    rd_ff [Lanes];
   logic                 accept;
   lane_cfg_type         lane_cfg;
   key_cfg_type          key_cfg;
   key_type              key;

   assign lane_cfg = '{ceiling: ceiling_ff, bleed: bleed_ff, warmup: warmup_ff, mix: mix_ff};
   assign key_cfg  = '{touch: touch_ff, pair: pair_ff, single: single_ff, middle: middle_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff <= 12'd2560;
         bleed_ff   <= 12'd512;
         warmup_ff  <= 8'd10;
         mix_ff     <= 16'd3277;
         touch_ff   <= 12'd256;
         pair_ff    <= 12'd768;
         single_ff  <= 12'd1536;
         middle_ff  <= 3'd3;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_LEVEL_CEILING:  ceiling_ff <= csr_wdata[LevelBits-1:0];
            REG_LEVEL_BLEED:    bleed_ff   <= csr_wdata[LevelBits-1:0];
            REG_WARMUP_SAMPLES: warmup_ff  <= csr_wdata[WarmBits-1:0];
            REG_BASELINE_MIX:   mix_ff     <= csr_wdata[MixBits-1:0];
            REG_TOUCH_LEVEL:    touch_ff   <= csr_wdata[LevelBits-1:0];
            REG_PAIR_LEVEL:     pair_ff    <= csr_wdata[LevelBits-1:0];
            REG_SINGLE_LEVEL:   single_ff  <= csr_wdata[LevelBits-1:0];
            REG_MIDDLE_COUNT:   middle_ff  <= csr_wdata[CountBits-1:0];
            default: ;
         endcase
      end
   end

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      load_out     = 1'b0;
      req_tready   = 1'b0;
      wcnt_in      = wcnt_ff;
      warm_in      = warm_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      case (state_ff)
         TOP_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               warm_in  = (wcnt_ff < warmup_ff);
               if (wcnt_ff < warmup_ff) wcnt_in = wcnt_ff + 1'b1;
               state_in = TOP_START;
            end
         end
         TOP_START: state_in = TOP_RUN;
         TOP_RUN: begin
            if (lane_busy == '0) state_in = TOP_DONE;
         end
         TOP_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         out_valid_ff <= 1'b0;
         wcnt_ff      <= '0;
         warm_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         wcnt_ff      <= wcnt_in;
         warm_ff      <= warm_in;
      end
   end

   for (genvar i = 0; i < Lanes; i++) begin : g_lane
      always_ff @(posedge clock) begin
         if (accept) begin
            rd_ff[i] <= RdBits'(req_tdata[i*RdBits +: READING_BITS]);
         end
      end

      tpakd_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (state_ff == TOP_START),
         .warm    (warm_ff),
         .reading (rd_ff[i]),
         .cfg     (lane_cfg),
         .busy    (lane_busy[i]),
         .level   (lane_level[i])
      );
   end

   tpakd_merge u_merge (
      .lv_right (lane_level[0]),
      .lv_up    (lane_level[1]),
      .lv_left  (lane_level[2]),
      .lv_down  (lane_level[3]),
      .cfg      (key_cfg),
      .key      (key)
   );

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= {5'b00000, lane_level[3], lane_level[2], lane_level[1],
                         lane_level[0], key};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
